>>> src/mss_pkg.sv
// Package for the masked signature scan unit.
// Holds sizes, item kinds, register indexes and the controller/datapath structs.
// No dependencies.
package mss_pkg;

  localparam int SIG_ENTRIES = 32;
  localparam int ENTRY_IDX_W = $clog2(SIG_ENTRIES);
  localparam int MATCH_LIMIT = 64;
  localparam int POSITION_BITS = 24;
  localparam int POS_W = POSITION_BITS + 1;
  localparam int CAND_W = POS_W + 1;
  localparam int WIN_DEPTH = 32;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int WORD_W = 32;
  localparam int OFF_W = 5;
  localparam int CNT_W = 6;
  localparam int SEEN_W = 7;
  localparam int ENTRY_W = OFF_W + 2 * WORD_W;
  localparam int IN_TDATA_W = 112;
  localparam int OUT_TDATA_W = 56;
  localparam int FLUSH_LAST = WIN_DEPTH - 2;
  localparam logic [WORD_W-1:0] PAD_WORD = '1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_SIG_LENGTH   = 1'b1;

  typedef struct packed {
    logic                 shift;
    logic                 pad;
    logic [WIN_IDX_W-1:0] flush_step;
    logic                 restart;
    logic                 clear;
    logic                 load;
    logic                 rd_en;
    logic [ENTRY_IDX_W-1:0] rd_addr;
    logic                 decide;
    logic                 emit;
  } mss_cmd_t;

  typedef struct packed {
    logic             pos_full;
    logic             cand_ok;
    logic [CNT_W-1:0] len_eff;
  } mss_sts_t;

  typedef struct packed {
    logic              overflow;
    logic [SEEN_W-1:0] match_count;
    logic [CNT_W-1:0]  best_misses;
    logic [CNT_W-1:0]  best_hits;
    logic [WORD_W-1:0] best_address;
    logic              found;
  } mss_result_t;

endpackage

>>> src/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/mss_ctrl.sv
// Controller of the masked signature scan unit: item decode, scoring sequence,
// end-of-stream flush and the result handshake. Depends on mss_pkg.
module mss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_kind,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  mss_pkg::mss_sts_t  sts,
  output mss_pkg::mss_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCORE  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [mss_pkg::CNT_W-1:0]       entry_r, entry_nxt;
  logic [mss_pkg::WIN_IDX_W-1:0]   step_r, step_nxt;
  logic                            flush_r, flush_nxt;
  logic                            out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    step_nxt      = step_r;
    flush_nxt     = flush_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    cmd.flush_step = step_r;
    cmd.rd_addr    = entry_r[mss_pkg::ENTRY_IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_kind)
            mss_pkg::KIND_CLEAR: begin
              cmd.restart = 1'b1;
              cmd.clear   = 1'b1;
            end
            mss_pkg::KIND_LOAD: begin
              cmd.load = 1'b1;
            end
            mss_pkg::KIND_DATA: begin
              if (!sts.pos_full) begin
                cmd.shift = 1'b1;
                if (sts.cand_ok) begin
                  state_nxt = S_SCORE;
                end
              end
            end
            mss_pkg::KIND_END: begin
              state_nxt = S_FLUSH;
              step_nxt  = '0;
              flush_nxt = 1'b1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCORE: begin
        if (entry_r == sts.len_eff) begin
          state_nxt = S_DECIDE;
          entry_nxt = '0;
        end else begin
          cmd.rd_en = 1'b1;
          entry_nxt = entry_r + 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!flush_r) begin
          state_nxt = S_IDLE;
        end else if (step_r == mss_pkg::WIN_IDX_W'(mss_pkg::FLUSH_LAST)) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.shift = 1'b1;
        cmd.pad   = 1'b1;
        if (sts.cand_ok) begin
          state_nxt = S_SCORE;
        end else if (step_r == mss_pkg::WIN_IDX_W'(mss_pkg::FLUSH_LAST)) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          cmd.restart   = 1'b1;
          out_valid_nxt = 1'b1;
          flush_nxt     = 1'b0;
          step_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      entry_r     <= '0;
      step_r      <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entry_r     <= entry_nxt;
      step_r      <= step_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/mss_dp.sv
// Datapath of the masked signature scan unit: word window, signature RAM,
// hit/miss counters, best-match tracking and result register.
// Depends on mss_pkg and mss_ram.
module mss_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mss_pkg::mss_cmd_t                cmd,
  output mss_pkg::mss_sts_t                sts,
  input  logic                             cfg_we,
  input  logic                             cfg_sel,
  input  logic [mss_pkg::WORD_W-1:0]       cfg_wdata,
  input  logic [mss_pkg::ENTRY_IDX_W-1:0]  entry_index,
  input  logic [mss_pkg::OFF_W-1:0]        entry_offset,
  input  logic [mss_pkg::WORD_W-1:0]       entry_value,
  input  logic [mss_pkg::WORD_W-1:0]       entry_mask,
  input  logic [mss_pkg::WORD_W-1:0]       data_word,
  output mss_pkg::mss_result_t             result
);

  logic [mss_pkg::WORD_W-1:0] win_r [mss_pkg::WIN_DEPTH];
  logic [mss_pkg::POS_W-1:0]  pos_r;
  logic [mss_pkg::CAND_W-1:0] cand_r;
  logic [mss_pkg::CAND_W-1:0] cand_sum;
  logic [mss_pkg::WORD_W-1:0] base_r;
  logic [mss_pkg::CNT_W-1:0]  len_r;
  logic [mss_pkg::CNT_W-1:0]  hits_r, misses_r;
  logic                       cmp_v_r;
  logic [mss_pkg::WORD_W-1:0] best_addr_r;
  logic [mss_pkg::CNT_W-1:0]  best_hits_r, best_misses_r;
  logic [mss_pkg::SEEN_W-1:0] seen_r;
  logic                       limit_r;
  mss_pkg::mss_result_t       result_r;

  logic [mss_pkg::ENTRY_W-1:0] entry_rd;
  logic [mss_pkg::OFF_W-1:0]   rd_off;
  logic [mss_pkg::WORD_W-1:0]  rd_value, rd_mask, tap_word;
  logic                        hit;
  logic [mss_pkg::WORD_W-1:0]  cand_addr;
  logic                        is_match, better, found;
  logic [mss_pkg::WORD_W-1:0]  shift_word;

  mss_ram #(
    .WIDTH (mss_pkg::ENTRY_W),
    .DEPTH (mss_pkg::SIG_ENTRIES)
  ) u_sig_ram (
    .clk     (clk),
    .wr_en   (cmd.load &
              ({1'b0, entry_index} < (mss_pkg::ENTRY_IDX_W + 1)'(mss_pkg::SIG_ENTRIES))),
    .wr_addr (entry_index),
    .wr_data ({entry_offset, entry_value, entry_mask}),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (entry_rd)
  );

  assign {rd_off, rd_value, rd_mask} = entry_rd;
  assign tap_word = win_r[rd_off[mss_pkg::WIN_IDX_W-1:0]];
  assign hit      = ((tap_word & rd_mask) == rd_value);

  assign cand_sum = {1'b0, pos_r} + mss_pkg::CAND_W'(cmd.flush_step);
  assign sts.cand_ok  = (cand_sum >= mss_pkg::CAND_W'(mss_pkg::WIN_DEPTH - 1));
  assign sts.pos_full = pos_r[mss_pkg::POSITION_BITS];
  assign sts.len_eff  = (len_r > mss_pkg::CNT_W'(mss_pkg::SIG_ENTRIES)) ?
                        mss_pkg::CNT_W'(mss_pkg::SIG_ENTRIES) : len_r;

  assign cand_addr = base_r + mss_pkg::WORD_W'({cand_r, 2'b00});
  assign is_match  = (hits_r > misses_r);
  assign better    = (seen_r == '0) || (hits_r > best_hits_r) ||
                     ((hits_r == best_hits_r) && (misses_r < best_misses_r)) ||
                     ((hits_r == best_hits_r) && (misses_r == best_misses_r) &&
                      (cand_addr < best_addr_r));
  assign found      = (seen_r != '0);
  assign shift_word = cmd.pad ? mss_pkg::PAD_WORD : data_word;
  assign result     = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mss_pkg::WIN_DEPTH; k++) begin
        win_r[k] <= mss_pkg::PAD_WORD;
      end
      pos_r   <= '0;
      base_r  <= '0;
      len_r   <= mss_pkg::CNT_W'(1);
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.rd_en;
      if (cfg_we) begin
        if (cfg_sel == mss_pkg::REG_BASE_ADDRESS) begin
          base_r <= cfg_wdata;
        end else begin
          len_r <= cfg_wdata[mss_pkg::CNT_W-1:0];
        end
      end
      if (cmd.restart) begin
        for (int k = 0; k < mss_pkg::WIN_DEPTH; k++) begin
          win_r[k] <= mss_pkg::PAD_WORD;
        end
        pos_r <= '0;
      end else if (cmd.shift) begin
        for (int k = 0; k < mss_pkg::WIN_DEPTH - 1; k++) begin
          win_r[k] <= win_r[k+1];
        end
        win_r[mss_pkg::WIN_DEPTH-1] <= shift_word;
        if (!cmd.pad) begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      cand_r   <= cand_sum - mss_pkg::CAND_W'(mss_pkg::WIN_DEPTH - 1);
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmp_v_r) begin
      if (hit) begin
        hits_r <= hits_r + 1'b1;
      end else begin
        misses_r <= misses_r + 1'b1;
      end
    end
    if (cmd.emit) begin
      result_r.found        <= found;
      result_r.best_address <= found ? best_addr_r : '0;
      result_r.best_hits    <= found ? best_hits_r : '0;
      result_r.best_misses  <= found ? best_misses_r : '0;
      result_r.match_count  <= seen_r;
      result_r.overflow     <= limit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      best_addr_r   <= '0;
      best_hits_r   <= '0;
      best_misses_r <= '0;
      seen_r        <= '0;
      limit_r       <= 1'b0;
    end else if (cmd.decide && is_match) begin
      if (seen_r >= mss_pkg::SEEN_W'(mss_pkg::MATCH_LIMIT)) begin
        limit_r <= 1'b1;
      end else begin
        if (better) begin
          best_addr_r   <= cand_addr;
          best_hits_r   <= hits_r;
          best_misses_r <= misses_r;
        end
        seen_r <= seen_r + 1'b1;
      end
    end
  end

endmodule

>>> src/masked_signature_scan_unit.sv
// Flow: clear and load beats are taken while idle; a data beat shifts its word in and, once 32
// words are in, scores a candidate over L entries, where L is the active signature length.
// An end beat takes 31 pad steps, scoring each candidate they complete, then loads the result
// register once the output is free. Beats are taken only while idle. The signature RAM, never
// cleared by reset, is read one entry per cycle while scoring. Reset is synchronous and active
// low: window all ones, match tracking cleared, base address 0, length 1.
module masked_signature_scan_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index[4:0], entry_offset[9:5], entry_value[41:10], entry_mask[73:42],
  // data_word[105:74], zero pad above.
  input  logic [mss_pkg::IN_TDATA_W-1:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // found[0], best_address[32:1], best_hits[38:33], best_misses[44:39],
  // match_count[51:45], overflow[52], zero pad above.
  output logic [mss_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  mss_pkg::mss_cmd_t    cmd;
  mss_pkg::mss_sts_t    sts;
  mss_pkg::mss_result_t result;

  assign cfg_ready = 1'b1;
  assign out_tdata = mss_pkg::OUT_TDATA_W'(result);

  mss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mss_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_sel      (cfg_index),
    .cfg_wdata    (cfg_data),
    .entry_index  (in_tdata[4:0]),
    .entry_offset (in_tdata[9:5]),
    .entry_value  (in_tdata[41:10]),
    .entry_mask   (in_tdata[73:42]),
    .data_word    (in_tdata[105:74]),
    .result       (result)
  );

endmodule

>>> src/mss_checker.sv
// Port-level checks of the masked signature scan unit, bound to the top level.
// Depends on mss_pkg and masked_signature_scan_unit.
module mss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mss_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[51:45] != 7'd0)))
    else $error("found disagrees with match count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[44:1] == 44'd0))
    else $error("best match fields not zero without a match");

  a_best_is_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[38:33] > out_tdata[44:39]))
    else $error("best match does not have more hits than misses");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[52] |->
      (out_tdata[51:45] == mss_pkg::SEEN_W'(mss_pkg::MATCH_LIMIT)))
    else $error("overflow flagged below the match limit");

endmodule

bind masked_signature_scan_unit mss_checker u_mss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/masked_signature_scan_unit_test.sv
// Self-checking testbench for masked_signature_scan_unit.
// Drives clear, signature load, image word and end beats and scores the stream in a
// behavioral scan model to check each report beat. Depends on mss_pkg and masked_signature_scan_unit.
module masked_signature_scan_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int OPENING_ROWS = 23;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  idx;
    logic [4:0]  off;
    logic [31:0] val;
    logic [31:0] mask;
    logic [31:0] word;
  } scan_beat_t;

  typedef struct packed {
    scan_beat_t  beat;
    logic        preset;
    mss_result_t report;
  } opening_row_t;

  localparam mss_result_t EMPTY_REPORT = '0;

  localparam opening_row_t OPENING[OPENING_ROWS] = '{
    '{'{KIND_END,   5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b1, EMPTY_REPORT},
    '{'{KIND_CLEAR, 5'd31, 5'd31, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, EMPTY_REPORT},
    '{'{KIND_LOAD,  5'd31, 5'd31, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_LOAD,  5'd0,  5'd0,  32'h0,        32'h0,        32'hFFFFFFFF}, 1'b0, EMPTY_REPORT},
    '{'{KIND_DATA,  5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_DATA,  5'd0,  5'd0,  32'h0,        32'h0,        32'hFFFFFFFF}, 1'b0, EMPTY_REPORT},
    '{'{KIND_END,   5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_END,   5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_CLEAR, 5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_LOAD,  5'd0,  5'd1,  32'h0,        32'hFFFFFFFF, 32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_DATA,  5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_DATA,  5'd0,  5'd0,  32'h0,        32'h0,        32'hA5A5A5A5}, 1'b0, EMPTY_REPORT},
    '{'{KIND_DATA,  5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_END,   5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_LOAD,  5'd0,  5'd0,  32'h1,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_DATA,  5'd0,  5'd0,  32'h0,        32'h0,        32'h12345678}, 1'b0, EMPTY_REPORT},
    '{'{KIND_END,   5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_CLEAR, 5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_END,   5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b1, EMPTY_REPORT},
    '{'{KIND_LOAD,  5'd0,  5'd31, 32'h80000001, 32'h80000001, 32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_DATA,  5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_END,   5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT},
    '{'{KIND_CLEAR, 5'd0,  5'd0,  32'h0,        32'h0,        32'h0},        1'b0, EMPTY_REPORT}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [31:0]            cfg_data = '0;

  logic [WORD_W-1:0] win_q [WIN_DEPTH];
  logic [OFF_W-1:0]  sig_off [SIG_ENTRIES];
  logic [WORD_W-1:0] sig_val [SIG_ENTRIES];
  logic [WORD_W-1:0] sig_mask [SIG_ENTRIES];
  bit                sig_loaded [SIG_ENTRIES];
  logic [POS_W-1:0]  stream_pos;
  logic [WORD_W-1:0] best_addr;
  logic [CNT_W-1:0]  best_hits;
  logic [CNT_W-1:0]  best_misses;
  logic [SEEN_W-1:0] seen_count;
  logic              over_limit;
  logic [WORD_W-1:0] base_reg;
  logic [5:0]        len_reg;

  mss_result_t scan_report_q [$];

  int fail_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  masked_signature_scan_unit u_top (.*);

  always #4 clk = ~clk;

  function automatic int active_len();
    return (len_reg > SIG_ENTRIES) ? SIG_ENTRIES : int'(len_reg);
  endfunction

  function automatic void restart_window();
    foreach (win_q[k]) win_q[k] = PAD_WORD;
    stream_pos = '0;
  endfunction

  function automatic void clear_ranking();
    best_addr = '0;
    best_hits = '0;
    best_misses = '0;
    seen_count = '0;
    over_limit = 1'b0;
  endfunction

  function automatic void reset_scan_model();
    base_reg = '0;
    len_reg = 6'd1;
    foreach (sig_off[e]) begin
      sig_off[e] = '0;
      sig_val[e] = '0;
      sig_mask[e] = '0;
      sig_loaded[e] = 1'b0;
    end
    restart_window();
    clear_ranking();
  endfunction

  function automatic void shift_word(logic [WORD_W-1:0] w);
    for (int k = 0; k < WIN_DEPTH - 1; k++) win_q[k] = win_q[k+1];
    win_q[WIN_DEPTH-1] = w;
  endfunction

  function automatic void rank_candidate(int cand);
    int hits;
    int misses;
    logic [WORD_W-1:0] addr;
    hits = 0;
    misses = 0;
    for (int e = 0; e < active_len(); e++) begin
      if ((win_q[sig_off[e]] & sig_mask[e]) == sig_val[e]) hits++;
      else misses++;
    end
    if (hits <= misses) return;
    if (seen_count >= MATCH_LIMIT) begin
      over_limit = 1'b1;
      return;
    end
    addr = base_reg + (32'(cand) << 2);
    if (seen_count == 0 || hits > best_hits ||
        (hits == best_hits && misses < best_misses) ||
        (hits == best_hits && misses == best_misses && addr < best_addr)) begin
      best_addr = addr;
      best_hits = CNT_W'(hits);
      best_misses = CNT_W'(misses);
    end
    seen_count++;
  endfunction

  function automatic bit advance_scan(scan_beat_t b, output mss_result_t report);
    report = '0;
    case (b.kind)
      KIND_CLEAR: begin
        restart_window();
        clear_ranking();
      end
      KIND_LOAD: begin
        sig_off[b.idx] = b.off;
        sig_val[b.idx] = b.val;
        sig_mask[b.idx] = b.mask;
        sig_loaded[b.idx] = 1'b1;
      end
      KIND_DATA: begin
        if (stream_pos < (1 << POSITION_BITS)) begin
          shift_word(b.word);
          stream_pos++;
          if (stream_pos >= WIN_DEPTH) rank_candidate(int'(stream_pos) - WIN_DEPTH);
        end
      end
      default: begin
        for (int t = 0; t < WIN_DEPTH - 1; t++) begin
          shift_word(PAD_WORD);
          if (int'(stream_pos) + t >= WIN_DEPTH - 1)
            rank_candidate(int'(stream_pos) + t - (WIN_DEPTH - 1));
        end
        report.found = (seen_count != 0);
        if (report.found) begin
          report.best_address = best_addr;
          report.best_hits = best_hits;
          report.best_misses = best_misses;
        end
        report.match_count = seen_count;
        report.overflow = over_limit;
        restart_window();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return '1;
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic scan_beat_t noise_beat(logic [1:0] kind);
    scan_beat_t b;
    b.kind = kind;
    b.idx = 5'($urandom());
    b.off = 5'($urandom());
    b.val = $urandom();
    b.mask = pick_mask();
    b.word = pick_word();
    return b;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic push_beat(scan_beat_t b, logic preset = 1'b0,
                           mss_result_t fixed_report = '0);
    mss_result_t report;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, b.word, b.mask, b.val, b.off, b.idx};
    in_tuser <= b.kind;
    do @(posedge clk); while (!in_tready);
    if (advance_scan(b, report)) scan_report_q.push_back(preset ? fixed_report : report);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_word(logic [31:0] w);
    scan_beat_t b;
    b = noise_beat(KIND_DATA);
    b.word = w;
    push_beat(b);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BASE_ADDRESS) base_reg = v;
    else len_reg = v[5:0];
    @(negedge clk);
  endtask

  task automatic settle_scan();
    in_tvalid <= 1'b0;
    while (scan_report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic play_planted(int n);
    logic [31:0] pat [WIN_DEPTH];
    scan_beat_t b;
    int copies;
    int cut;
    foreach (pat[k]) pat[k] = pick_word();
    if ($urandom_range(0, 1) == 0) push_beat(noise_beat(KIND_CLEAR));
    for (int e = 0; e < n; e++) begin
      b = noise_beat(KIND_LOAD);
      b.idx = 5'(e);
      b.val = pat[b.off] & b.mask;
      if ($urandom_range(0, 15) == 0) b.val = $urandom();
      push_beat(b);
    end
    repeat ($urandom_range(1, 2)) begin
      repeat ($urandom_range(0, 24)) push_word(pick_word());
      copies = $urandom_range(1, 3);
      for (int c = 0; c < copies; c++) begin
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, WIN_DEPTH - 1) : WIN_DEPTH;
        for (int k = 0; k < cut; k++)
          push_word(($urandom_range(0, 7) == 0) ? pick_word() : pat[k]);
        repeat ($urandom_range(0, 8)) push_word(pick_word());
      end
      push_beat(noise_beat(KIND_END));
    end
  endtask

  task automatic play_flood(int n);
    scan_beat_t b;
    push_beat(noise_beat(KIND_CLEAR));
    for (int e = 0; e < n; e++) begin
      b = noise_beat(KIND_LOAD);
      b.idx = 5'(e);
      if ($urandom_range(0, 3) != 0) begin
        b.mask = '0;
        b.val = '0;
      end else begin
        b.val = b.val & b.mask;
      end
      push_beat(b);
    end
    repeat ($urandom_range(40, 110)) push_word(pick_word());
    push_beat(noise_beat(KIND_END));
  endtask

  task automatic play_noise(int n);
    scan_beat_t b;
    for (int e = 0; e < n; e++) begin
      if (!sig_loaded[e]) begin
        b = noise_beat(KIND_LOAD);
        b.idx = 5'(e);
        push_beat(b);
      end
    end
    repeat ($urandom_range(20, 60)) begin
      case ($urandom_range(0, 19))
        0: push_beat(noise_beat(KIND_CLEAR));
        1, 2, 3, 4: push_beat(noise_beat(KIND_LOAD));
        17, 18, 19: push_beat(noise_beat(KIND_END));
        default: push_beat(noise_beat(KIND_DATA));
      endcase
    end
    push_beat(noise_beat(KIND_END));
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mss_result_t got_report;
    mss_result_t want_report;
    if (rst_n && out_tvalid && out_tready) begin
      got_report = out_tdata[$bits(mss_result_t)-1:0];
      if (scan_report_q.size() == 0) begin
        $error("result beat arrived with no report pending");
        fail_count++;
      end else begin
        want_report = scan_report_q.pop_front();
        check_field("found", want_report.found, got_report.found);
        check_field("best_address", want_report.best_address, got_report.best_address);
        check_field("best_hits", want_report.best_hits, got_report.best_hits);
        check_field("best_misses", want_report.best_misses, got_report.best_misses);
        check_field("match_count", want_report.match_count, got_report.match_count);
        check_field("overflow", want_report.overflow, got_report.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("masked_signature_scan_unit regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] preset_base [5];
    logic [31:0] preset_len [5];
    logic [31:0] base;
    logic [31:0] len_word;
    int          phase;
    int          style;
    int          pick;
    preset_base = '{32'h0, 32'hFFFFFFFC, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFF0};
    preset_len = '{32'd32, 32'd1, 32'd63, 32'd0, 32'd33};
    reset_scan_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int r = 0; r < OPENING_ROWS; r++)
      push_beat(OPENING[r].beat, OPENING[r].preset, OPENING[r].report);
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_scan();
      if (phase < 5) begin
        base = preset_base[phase];
        len_word = preset_len[phase];
      end else begin
        case ($urandom_range(0, 5))
          0: base = '0;
          1: base = '1;
          2: base = 32'hFFFFFFFC;
          default: base = $urandom();
        endcase
        case ($urandom_range(0, 9))
          0: len_word = 32'd0;
          1: len_word = 32'd32;
          2: len_word = $urandom_range(33, 63);
          default: len_word = $urandom_range(1, 32);
        endcase
        if ($urandom_range(0, 3) == 0) len_word = len_word | ($urandom() & ~32'h3F);
      end
      write_reg(REG_BASE_ADDRESS, base);
      write_reg(REG_SIG_LENGTH, len_word);
      cfg_valid <= 1'b0;
      idle_on = (items_sent < ITEM_TARGET * 7 / 8);
      if (phase < 5) begin
        style = (phase == 1 || phase == 4) ? 1 : (phase == 2) ? 2 : 0;
      end else begin
        pick = $urandom_range(0, 9);
        style = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
      end
      case (style)
        0: play_planted(active_len());
        1: play_flood(active_len());
        default: play_noise(active_len());
      endcase
      phase++;
    end
    settle_scan();
    if (fail_count == 0) begin
      $display("masked_signature_scan_unit regression: pass");
    end else begin
      $display("masked_signature_scan_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> masked_signature_scan_unit.f
src/mss_pkg.sv
src/mss_ram.sv
src/mss_ctrl.sv
src/mss_dp.sv
src/masked_signature_scan_unit.sv
src/mss_checker.sv
tb/sv/masked_signature_scan_unit_test.sv
